// ----- sv/bfdh_pkg.sv -----
// bfdh_pkg: shared types, codes and constants of the double hash bloom filter
// used by the controller, the datapath and the top level; no dependencies
`timescale 1ns / 1ps

package bfdh_pkg;

    localparam int MAX_BITS_DEF   = 65536;
    localparam int MAX_HASHES_DEF = 32;
    localparam int WORD_BITS      = 64;
    localparam int WORD_SHIFT     = 6;
    localparam int HASH_W         = 64;
    localparam int DIV_STEPS      = 4;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;
    localparam int COUNT_W        = 32;

    localparam logic [16:0] NUM_BITS_RST    = 17'h10000;
    localparam logic [5:0]  HASH_COUNT_RST  = 6'd7;
    localparam logic [31:0] EXPECTED_RST    = 32'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_BITS   = 2'd0,
        CFG_HASH_COUNT = 2'd1,
        CFG_EXPECTED   = 2'd2
    } t_cfg_idx;

    typedef enum logic [0:0] {
        REQ_INSERT = 1'b0,
        REQ_QUERY  = 1'b1
    } t_req_kind;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_NO_CHANGE = 2'd1,
        ST_FULL      = 2'd2,
        ST_QUERY     = 2'd3
    } t_status;

    typedef struct packed {
        t_req_kind         req_type;
        logic [HASH_W-1:0] hash_first;
        logic [HASH_W-1:0] hash_second;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic               maybe_present;
        logic [COUNT_W-1:0] entry_count;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic accept;
        logic div_step;
        logic seed;
        logic rd;
        logic check;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic skip;
        logic div_done;
        logic last_probe;
        logic miss;
    } t_dp_sts;

endpackage

// ----- sv/bfdh_ctrl.sv -----
// bfdh_ctrl: sequencing state machine of the bloom filter
// depends on bfdh_pkg for the command and status structs
`timescale 1ns / 1ps

module bfdh_ctrl
    import bfdh_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_DIVIDE = 7'b0000100,
        S_SEED   = 7'b0001000,
        S_READ   = 7'b0010000,
        S_CHECK  = 7'b0100000,
        S_RESULT = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   load_out;

    assign load_out = (r_state == S_RESULT) && (!r_out_valid || i_out_ready);

    always_comb begin
        o_cmd          = '0;
        o_cmd.clear    = (r_state == S_CLEAR);
        o_cmd.accept   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.div_step = (r_state == S_DIVIDE);
        o_cmd.seed     = (r_state == S_SEED);
        o_cmd.rd       = (r_state == S_READ);
        o_cmd.check    = (r_state == S_CHECK);
        o_cmd.load_out = load_out;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = i_sts.skip ? S_RESULT : S_DIVIDE;
            end
            S_DIVIDE: begin
                if (i_sts.div_done) n_state = S_SEED;
            end
            S_SEED:  n_state = S_READ;
            S_READ:  n_state = S_CHECK;
            S_CHECK: begin
                // a query stops at the first clear bit
                if (i_sts.last_probe || i_sts.miss) n_state = S_RESULT;
                else n_state = S_READ;
            end
            S_RESULT: begin
                if (load_out) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- sv/bfdh_datapath.sv -----
// bfdh_datapath: config registers, remainder unit, probe walker, bit store
// and result register of the bloom filter; depends on bfdh_pkg
`timescale 1ns / 1ps

module bfdh_datapath
    import bfdh_pkg::*;
#(
    parameter int MAX_BITS   = MAX_BITS_DEF,
    parameter int MAX_HASHES = MAX_HASHES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  t_req                  i_in,
    output t_rsp                  o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int MAX_WORDS = MAX_BITS / WORD_BITS;
    localparam int AW        = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int BW        = AW + WORD_SHIFT;
    localparam int QW        = HASH_W - WORD_SHIFT;
    // at least one spare dividend bit so 2^QW fits for the wrap offset
    localparam int ITERS     = (QW + DIV_STEPS) / DIV_STEPS;
    localparam int DIVW      = ITERS * DIV_STEPS;
    localparam int ITW       = (ITERS > 1) ? $clog2(ITERS) : 1;
    localparam int KW        = $clog2(MAX_HASHES + 1);
    localparam logic [DIVW-1:0] WRAP_DIV = DIVW'(1) << QW;

    // configuration
    logic [16:0]        r_num_bits;
    logic [5:0]         r_hash_count;
    logic [COUNT_W-1:0] r_expected;

    // item state
    t_req_kind             r_req;
    logic                  r_reject;
    logic                  r_changed;
    logic                  r_present;
    logic [DIVW-1:0]       r_div_a, r_div_b, r_div_c;
    logic [AW:0]           r_rem_a, r_rem_b, r_rem_c;
    logic [AW:0]           n_rem_a, n_rem_b, n_rem_c;
    logic [ITW-1:0]        r_div_cnt;
    logic [WORD_SHIFT-1:0] r_lo_a, r_lo_b;
    logic [BW-1:0]         r_pos, r_step, r_wrap;
    logic [HASH_W-1:0]     r_hpos, r_hstep;
    logic [KW-1:0]         r_probe;
    logic [COUNT_W-1:0]    r_entries;
    logic [AW-1:0]         r_clr;
    t_rsp                  r_out;

    // bit store
    logic [WORD_BITS-1:0] mem [MAX_WORDS];
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;

    logic [31:0]          m_wide;
    logic [AW:0]          m_eff;
    logic [6:0]           k_wide;
    logic [KW-1:0]        k_eff;
    logic                 full;
    logic [BW:0]          n_bits, sum, pos_red, wrap_w, pos_next_w;
    logic [HASH_W:0]      hsum;
    logic [AW:0]          ta, tb, tc;
    logic [WORD_BITS-1:0] mask;
    logic                 hit;
    logic                 ins_changed;
    logic [COUNT_W-1:0]   entries_next;
    t_status              status_next;

    // store size in words, rounded down, at least one and at most the store; probe count at most MAX_HASHES
    always_comb begin
        m_wide = {21'b0, r_num_bits[16:WORD_SHIFT]};
        if (m_wide == 32'd0) m_wide = 32'd1;
        else if (m_wide > 32'(MAX_WORDS)) m_wide = 32'(MAX_WORDS);
        m_eff = m_wide[AW:0];

        k_wide = {1'b0, r_hash_count};
        if (k_wide > 7'(MAX_HASHES)) k_wide = 7'(MAX_HASHES);
        k_eff = k_wide[KW-1:0];
    end

    assign full   = (r_entries >= r_expected);
    assign n_bits = {m_eff, {WORD_SHIFT{1'b0}}};

    // remainder of both word quotients and of 2^QW, DIV_STEPS dividend bits per step
    always_comb begin
        n_rem_a = r_rem_a;
        n_rem_b = r_rem_b;
        n_rem_c = r_rem_c;
        ta      = '0;
        tb      = '0;
        tc      = '0;
        for (int j = 0; j < DIV_STEPS; j++) begin
            ta = {n_rem_a[AW-1:0], r_div_a[DIVW-1-j]};
            if (ta >= m_eff) ta = ta - m_eff;
            n_rem_a = ta;
            tb = {n_rem_b[AW-1:0], r_div_b[DIVW-1-j]};
            if (tb >= m_eff) tb = tb - m_eff;
            n_rem_b = tb;
            tc = {n_rem_c[AW-1:0], r_div_c[DIVW-1-j]};
            if (tc >= m_eff) tc = tc - m_eff;
            n_rem_c = tc;
        end
    end

    // pos and step are below n, one conditional subtract keeps pos mod n;
    // when the full 64-bit position wraps, 2^64 mod n is taken back out
    always_comb begin
        hsum    = {1'b0, r_hpos} + {1'b0, r_hstep};
        sum     = {1'b0, r_pos} + {1'b0, r_step};
        pos_red = (sum >= n_bits) ? (sum - n_bits) : sum;
        wrap_w  = {1'b0, r_wrap};
        if (hsum[HASH_W])
            pos_next_w = (pos_red >= wrap_w) ? (pos_red - wrap_w)
                                             : (pos_red + n_bits - wrap_w);
        else
            pos_next_w = pos_red;
    end

    assign mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << r_pos[WORD_SHIFT-1:0];
    assign hit  = r_rd_data[r_pos[WORD_SHIFT-1:0]];

    assign mem_we    = i_cmd.clear || (i_cmd.check && (r_req == REQ_INSERT));
    assign mem_waddr = i_cmd.clear ? r_clr : r_pos[BW-1:WORD_SHIFT];
    assign mem_wdata = i_cmd.clear ? '0 : (r_rd_data | mask);

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (i_cmd.rd) r_rd_data <= mem[r_pos[BW-1:WORD_SHIFT]];
    end

    always_comb begin
        ins_changed  = (r_req == REQ_INSERT) && !r_reject && r_changed;
        entries_next = r_entries + COUNT_W'(ins_changed);
        if (r_req == REQ_QUERY) status_next = ST_QUERY;
        else if (r_reject) status_next = ST_FULL;
        else if (r_changed) status_next = ST_INSERTED;
        else status_next = ST_NO_CHANGE;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_bits   <= NUM_BITS_RST;
            r_hash_count <= HASH_COUNT_RST;
            r_expected   <= EXPECTED_RST;
            r_entries    <= '0;
            r_clr        <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NUM_BITS:   r_num_bits   <= i_cfg_data[16:0];
                    CFG_HASH_COUNT: r_hash_count <= i_cfg_data[5:0];
                    CFG_EXPECTED:   r_expected   <= i_cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clear) r_clr <= r_clr + AW'(1);
            if (i_cmd.load_out) r_entries <= entries_next;
        end
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req     <= i_in.req_type;
            r_reject  <= (i_in.req_type == REQ_INSERT) && full;
            r_changed <= 1'b0;
            r_present <= 1'b1;
            r_div_a   <= DIVW'(i_in.hash_first[HASH_W-1:WORD_SHIFT]);
            r_div_b   <= DIVW'(i_in.hash_second[HASH_W-1:WORD_SHIFT]);
            r_div_c   <= WRAP_DIV;
            r_lo_a    <= i_in.hash_first[WORD_SHIFT-1:0];
            r_lo_b    <= i_in.hash_second[WORD_SHIFT-1:0];
            r_hpos    <= i_in.hash_first;
            r_hstep   <= i_in.hash_second;
            r_rem_a   <= '0;
            r_rem_b   <= '0;
            r_rem_c   <= '0;
            r_div_cnt <= '0;
            r_probe   <= '0;
        end
        if (i_cmd.div_step) begin
            r_div_a   <= r_div_a << DIV_STEPS;
            r_div_b   <= r_div_b << DIV_STEPS;
            r_div_c   <= r_div_c << DIV_STEPS;
            r_rem_a   <= n_rem_a;
            r_rem_b   <= n_rem_b;
            r_rem_c   <= n_rem_c;
            r_div_cnt <= r_div_cnt + ITW'(1);
        end
        if (i_cmd.seed) begin
            r_pos  <= {r_rem_a[AW-1:0], r_lo_a};
            r_step <= {r_rem_b[AW-1:0], r_lo_b};
            r_wrap <= {r_rem_c[AW-1:0], {WORD_SHIFT{1'b0}}};
        end
        if (i_cmd.check) begin
            if (!hit) begin
                r_changed <= 1'b1;
                r_present <= 1'b0;
            end
            r_pos   <= pos_next_w[BW-1:0];
            r_hpos  <= hsum[HASH_W-1:0];
            r_probe <= r_probe + KW'(1);
        end
        if (i_cmd.load_out) begin
            r_out.status        <= status_next;
            r_out.maybe_present <= (r_req == REQ_QUERY) && r_present;
            r_out.entry_count   <= entries_next;
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.clear_done = (r_clr == AW'(MAX_WORDS - 1));
        o_sts.skip       = (k_eff == '0) || ((i_in.req_type == REQ_INSERT) && full);
        o_sts.div_done   = (r_div_cnt == ITW'(ITERS - 1));
        o_sts.last_probe = (r_probe == k_eff - KW'(1));
        o_sts.miss       = (r_req == REQ_QUERY) && !hit;
    end

    assign o_out = r_out;

endmodule

// ----- sv/bloom_filter_double_hash_unit.sv -----
// After reset the unit sweeps its bit store to zero, one 64-bit word per cycle,
// with in_ready low; configuration writes are taken during the sweep. Each
// transfer then runs from its accept cycle until in_ready returns through these
// steps, k being the probe count: the accept cycle, the remainder unit that
// reduces both hashes and the 64-bit wrap offset modulo the store size four bits
// a cycle, a seed step, for each of the k probes a read of the store word and a
// check that writes it back on an insert, and a step that loads the result
// register; a result still waiting at the output holds that last step. A query
// ends at its first clear bit; a rejected insert or a zero probe count goes from
// the accept cycle straight to the result load.
// Depends on bfdh_pkg, bfdh_ctrl and bfdh_datapath.
`timescale 1ns / 1ps

module bloom_filter_double_hash_unit
    import bfdh_pkg::*;
#(
    parameter int MAX_BITS   = MAX_BITS_DEF,
    parameter int MAX_HASHES = MAX_HASHES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_req                  i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_rsp                  o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    bfdh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    bfdh_datapath #(
        .MAX_BITS   (MAX_BITS),
        .MAX_HASHES (MAX_HASHES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // one item at a time: no new transfer right after one is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |=> !o_in_ready)
        else $error("input ready right after a transfer");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> o_out_valid)
        else $error("loaded result not presented");

    a_insert_not_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status != ST_QUERY)) |-> !o_out.maybe_present)
        else $error("insert result flagged maybe present");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !cmd.load_out)
        else $error("pending result overwritten");

endmodule

// ----- bench/tb_bloom_filter_double_hash_unit.sv -----
// tb_bloom_filter_double_hash_unit: self-checking bench for the double hash bloom filter,
// directed corner cases then randomized phases checked against an in-bench filter model
// depends on bfdh_pkg and bloom_filter_double_hash_unit
`timescale 1ns / 1ps

module tb_bloom_filter_double_hash_unit;
    import bfdh_pkg::*;

    localparam longint unsigned TIMEOUT_NS = 64'd10_000_000;
    localparam int STORE_WORDS = MAX_BITS_DEF / WORD_BITS;
    localparam int STORE_AW = $clog2(STORE_WORDS);
    localparam int HISTORY_MAX = 64;
    localparam int PRINT_MAX = 100;
    localparam int TAIL_CYCLES = 100;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_req i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_rsp o_out;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // model state, mirrors the unit's registers and store
    logic [WORD_BITS-1:0] filter_store [STORE_WORDS] = '{default: '0};
    logic [COUNT_W-1:0] filter_entries = '0;
    logic [16:0] cfg_num_bits = NUM_BITS_RST;
    logic [5:0] cfg_hash_count = HASH_COUNT_RST;
    logic [31:0] cfg_expected = EXPECTED_RST;

    t_rsp rsp_due_q[$];
    t_req pair_history[$];
    int unsigned mismatches = 0;
    int unsigned rx_hold_cycles = 0;
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;

    bloom_filter_double_hash_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    // walks the probes of one request and updates the model store
    function automatic t_rsp bloom_apply(input t_req req);
        logic [63:0] size;
        logic [63:0] pos;
        logic [63:0] bitpos;
        logic [STORE_AW-1:0] widx;
        int unsigned probes;
        int unsigned i;
        logic hit;
        logic changed;
        t_rsp rsp;
        size = {47'd0, cfg_num_bits[16:6], 6'd0};
        if (size < 64'd64) size = 64'd64;
        if (size > 64'(MAX_BITS_DEF)) size = 64'(MAX_BITS_DEF);
        probes = (cfg_hash_count > MAX_HASHES_DEF) ? MAX_HASHES_DEF : cfg_hash_count;
        pos = req.hash_first;
        rsp = '0;
        if (req.req_type == REQ_QUERY) begin
            hit = 1'b1;
            for (i = 0; i < probes && hit; i++) begin
                bitpos = pos % size;
                widx = bitpos[WORD_SHIFT +: STORE_AW];
                if (!filter_store[widx][bitpos[5:0]]) hit = 1'b0;
                pos = pos + req.hash_second;
            end
            rsp.status = ST_QUERY;
            rsp.maybe_present = hit;
        end else if (filter_entries >= cfg_expected) begin
            rsp.status = ST_FULL;
        end else begin
            changed = 1'b0;
            for (i = 0; i < probes; i++) begin
                bitpos = pos % size;
                widx = bitpos[WORD_SHIFT +: STORE_AW];
                if (!filter_store[widx][bitpos[5:0]]) changed = 1'b1;
                filter_store[widx][bitpos[5:0]] = 1'b1;
                pos = pos + req.hash_second;
            end
            if (changed) begin
                filter_entries = filter_entries + 1;
                rsp.status = ST_INSERTED;
            end else begin
                rsp.status = ST_NO_CHANGE;
            end
        end
        rsp.entry_count = filter_entries;
        return rsp;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(1, 3);
        else if (roll < 96) return $urandom_range(4, 12);
        else return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] random_hash();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 64'($urandom_range(0, 255));
            3: return {1'b1, 31'($urandom), 32'($urandom)};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_req make_req(input t_req_kind kind, input logic [63:0] first,
                                      input logic [63:0] second);
        t_req req;
        req.req_type = kind;
        req.hash_first = first;
        req.hash_second = second;
        return req;
    endfunction

    // reuses inserted pairs so that queries hit and repeat inserts see no change
    function automatic t_req random_req();
        t_req req;
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (pair_history.size() != 0 && roll < 4) begin
            req = pair_history[$urandom_range(0, pair_history.size() - 1)];
            req.req_type = (roll < 3) ? REQ_QUERY : REQ_INSERT;
        end else begin
            req = make_req($urandom_range(0, 1) ? REQ_QUERY : REQ_INSERT,
                           random_hash(), random_hash());
        end
        return req;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_MAX)
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic send_item(input t_req req);
        int unsigned gap;
        if (tx_idle_en && $urandom_range(0, 2) == 0) begin
            gap = pick_gap();
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= req;
        do @(posedge i_clk); while (!o_in_ready);
        rsp_due_q.push_back(bloom_apply(req));
        if (req.req_type == REQ_INSERT) begin
            pair_history.push_back(req);
            if (pair_history.size() > HISTORY_MAX) void'(pair_history.pop_front());
        end
    endtask

    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        while (rsp_due_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_NUM_BITS:   cfg_num_bits = data[16:0];
            CFG_HASH_COUNT: cfg_hash_count = data[5:0];
            CFG_EXPECTED:   cfg_expected = data;
            default: ;
        endcase
    endtask

    // receiver: random stalls, or one long hold-off on request
    initial begin : out_ready_drive
        int unsigned stall_left;
        int unsigned hold;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles != 0) begin
                hold = rx_hold_cycles;
                rx_hold_cycles = 0;
                i_out_ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end else if (stall_left != 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap() - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rsp_due_q.size() == 0) begin
                report_mismatch("result with none due", 64'(o_out), '0);
            end else begin
                want = rsp_due_q.pop_front();
                if (o_out.status !== want.status)
                    report_mismatch("status", 64'(o_out.status), 64'(want.status));
                if (o_out.maybe_present !== want.maybe_present)
                    report_mismatch("maybe_present", 64'(o_out.maybe_present),
                                    64'(want.maybe_present));
                if (o_out.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 64'(o_out.entry_count),
                                    64'(want.entry_count));
            end
        end
    end

    // reset values: empty store, repeat insert, all-ones hashes
    task automatic test_reset_defaults();
        send_item(make_req(REQ_QUERY, '0, '0));
        send_item(make_req(REQ_INSERT, '0, '0));
        send_item(make_req(REQ_INSERT, '0, '0));
        send_item(make_req(REQ_QUERY, '0, '0));
        send_item(make_req(REQ_INSERT, '1, '1));
        send_item(make_req(REQ_QUERY, '1, 64'd1));
        wait_results_done();
    endtask

    // smallest store, out of range sizes, old bits kept when the size shrinks
    task automatic test_store_size_edges();
        write_cfg(CFG_NUM_BITS, 32'd64);
        write_cfg(CFG_HASH_COUNT, 32'd1);
        send_item(make_req(REQ_INSERT, 64'h40, '0));
        send_item(make_req(REQ_INSERT, 64'd63, '0));
        send_item(make_req(REQ_QUERY, '1, '0));
        wait_results_done();
        // upper data bits dropped, then clipped to the largest store
        write_cfg(CFG_NUM_BITS, 32'hFFFF_FFFF);
        send_item(make_req(REQ_QUERY, '1, '0));
        wait_results_done();
        write_cfg(CFG_NUM_BITS, 32'h0002_0000);
        send_item(make_req(REQ_INSERT, 64'hDEAD_BEEF_0BAD_F00D, 64'd7));
        wait_results_done();
        write_cfg(CFG_NUM_BITS, 32'd100);
        write_cfg(CFG_NUM_BITS, 32'd4160);
        send_item(make_req(REQ_INSERT, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210));
        send_item(make_req(REQ_QUERY, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210));
        wait_results_done();
    endtask

    // zero probes, saturated probe count, ignored register index
    task automatic test_probe_count_edges();
        write_cfg(CFG_HASH_COUNT, 32'd0);
        send_item(make_req(REQ_INSERT, 64'h5555_AAAA_5555_AAAA, 64'd3));
        send_item(make_req(REQ_QUERY, 64'h1357_9BDF_2468_ACE0, 64'd9));
        wait_results_done();
        write_cfg(CFG_HASH_COUNT, 32'd63);
        send_item(make_req(REQ_INSERT, 64'd5, 64'd1));
        send_item(make_req(REQ_QUERY, 64'd5, 64'd1));
        send_item(make_req(REQ_QUERY, 64'd5, 64'd2));
        wait_results_done();
        write_cfg(CFG_HASH_COUNT, 32'd32);
        send_item(make_req(REQ_INSERT, '1, 64'h8000_0000_0000_0001));
        wait_results_done();
        write_cfg(CFG_UNUSED_IDX, 32'd0);
        send_item(make_req(REQ_QUERY, '1, 64'h8000_0000_0000_0001));
        wait_results_done();
    endtask

    // insert rejection at the entry limit
    task automatic test_entry_limit();
        write_cfg(CFG_NUM_BITS, 32'd65536);
        write_cfg(CFG_EXPECTED, 32'd0);
        send_item(make_req(REQ_INSERT, 64'h0F0F_0F0F_0F0F_0F0F, 64'd11));
        wait_results_done();
        write_cfg(CFG_EXPECTED, filter_entries + 1);
        send_item(make_req(REQ_INSERT, 64'h7777_1111_3333_9999, 64'h0000_0001_0000_0003));
        send_item(make_req(REQ_INSERT, 64'h2468_1357_ABCD_0000, 64'h0000_0000_0001_0001));
        send_item(make_req(REQ_QUERY, 64'h2468_1357_ABCD_0000, 64'h0000_0000_0001_0001));
        wait_results_done();
        write_cfg(CFG_EXPECTED, 32'hFFFF_FFFF);
        send_item(make_req(REQ_INSERT, 64'h2468_1357_ABCD_0000, 64'h0000_0000_0001_0001));
        wait_results_done();
    endtask

    // receiver holds off while the sender keeps offering, unit backs up
    task automatic test_receiver_hold();
        write_cfg(CFG_HASH_COUNT, 32'd4);
        tx_idle_en = 1'b0;
        rx_hold_cycles = 400;
        repeat (16) send_item(random_req());
        wait_results_done();
        tx_idle_en = 1'b1;
    endtask

    // each phase takes a fresh setting, runs a burst, then drains
    task automatic test_random_phases();
        int phase;
        logic [CFG_DATA_W-1:0] data;
        for (phase = 0; phase < 10; phase++) begin
            case ($urandom_range(0, 5))
                0: data = 32'd64;
                1: data = 32'd65536;
                2: data = $urandom_range(1, 16) * 64;
                3: data = $urandom_range(1, 1024) * 64;
                4: data = $urandom;
                default: data = $urandom_range(0, 131071);
            endcase
            write_cfg(CFG_NUM_BITS, data);
            case ($urandom_range(0, 7))
                0: data = 32'd0;
                1: data = 32'd63;
                2: data = 32'd32;
                3: data = $urandom_range(33, 63);
                default: data = $urandom_range(1, 8);
            endcase
            write_cfg(CFG_HASH_COUNT, data);
            case ($urandom_range(0, 5))
                0: data = 32'd0;
                1: data = 32'hFFFF_FFFF;
                2: data = $urandom;
                default: data = filter_entries + $urandom_range(0, 40);
            endcase
            write_cfg(CFG_EXPECTED, data);
            if ($urandom_range(0, 3) == 0) write_cfg(CFG_UNUSED_IDX, $urandom);
            tx_idle_en = (phase % 4 != 0);
            rx_idle_en = (phase % 4 != 0);
            repeat (65) send_item(random_req());
            wait_results_done();
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_store_size_edges();
        test_probe_count_edges();
        test_entry_limit();
        test_receiver_hold();
        test_random_phases();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- bloom_filter_double_hash_unit.f -----
sv/bfdh_pkg.sv
sv/bfdh_ctrl.sv
sv/bfdh_datapath.sv
sv/bloom_filter_double_hash_unit.sv
bench/tb_bloom_filter_double_hash_unit.sv
